// ----- design/cau_pkg.sv -----
// Shared types, codes and saturation helpers of the complex arithmetic unit.
`default_nettype none

package cau_pkg;

    localparam int MAX_EXPONENT = 64;
    localparam int POW_CNT_W    = $clog2(MAX_EXPONENT + 1);
    localparam int STEP_W       = 5;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(31);

    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_OVF     = 2'd1;
    localparam logic [1:0] STATUS_DIVZERO = 2'd2;

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_CONJMUL = 4'd3,
        OP_DIV     = 4'd4,
        OP_NEG     = 4'd5,
        OP_CONJ    = 4'd6,
        OP_SCALE   = 4'd7,
        OP_NORMSQ  = 4'd8,
        OP_NORM    = 4'd9,
        OP_POW     = 4'd10
    } opcode_t;

    // Operand routing to the four multipliers.
    typedef enum logic [2:0] {
        MS_XY    = 3'd0,
        MS_YY    = 3'd1,
        MS_XX    = 3'd2,
        MS_SCALE = 3'd3,
        MS_POW   = 3'd4
    } mul_sel_t;

    // How the four products combine into the real and imaginary sums.
    typedef enum logic [1:0] {
        CM_SUM  = 2'd0,
        CM_MUL  = 2'd1,
        CM_CONJ = 2'd2,
        CM_DIV  = 2'd3
    } comb_t;

    typedef struct packed {
        logic     load;
        logic     simple_wr;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     add_en;
        comb_t    comb;
        logic     fix_wr;
        logic     d_load;
        logic     dz_wr;
        logic     div_load;
        logic     load_im;
        logic     div_step;
        logic     div_wr;
        logic     wr_im;
        logic     to_base;
        logic     sq_load;
        logic     sq_step;
        logic     sq_wr;
        logic     one_wr;
    } cmd_t;

    typedef struct packed {
        logic d_zero;
    } stat_t;

    // Saturate a 33-bit signed value; the top bit of the result is the overflow flag.
    function automatic logic [32:0] sat33(input logic signed [32:0] v);
        logic [32:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
        end
        else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    // Saturate a sign and magnitude pair to 32 bits signed.
    function automatic logic [32:0] sat_sm(input logic neg, input logic [64:0] mag);
        logic [32:0] r;
        if (!neg) begin
            if (mag > 65'h0_7FFF_FFFF) begin
                r = {1'b1, 32'h7FFF_FFFF};
            end
            else begin
                r = {1'b0, mag[31:0]};
            end
        end
        else begin
            if (mag > 65'h0_8000_0000) begin
                r = {1'b1, 32'h8000_0000};
            end
            else begin
                r = {1'b0, 32'h0 - mag[31:0]};
            end
        end
        return r;
    endfunction

    // Q32.32 to Q16.16 with truncation toward minus infinity and saturation.
    function automatic logic [32:0] fix_q(input logic signed [64:0] s);
        logic [48:0] t;
        logic [32:0] r;
        t = s[64:16];
        if (!t[48] && (t[47:31] != '0)) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end
        else if (t[48] && (t[47:31] != '1)) begin
            r = {1'b1, 32'h8000_0000};
        end
        else begin
            r = {1'b0, t[31:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/complex_arithmetic_unit.sv -----
// Top level of the complex arithmetic unit: controller plus datapath.
// Pow does one multiplication step per unit of exponent magnitude, clamped to 64, and a
// negative exponent first takes the reciprocal of the base.
// One request at a time; busy stays high through the one-cycle done strobe, which never stalls.
// Reset (rst_n low, asynchronous) returns the controller to idle and clears the flags.
`default_nettype none

module complex_arithmetic_unit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [3:0]           opcode,
    input  wire logic signed [31:0]   operand_a_re,
    input  wire logic signed [31:0]   operand_a_im,
    input  wire logic signed [31:0]   operand_b_re,
    input  wire logic signed [31:0]   operand_b_im,
    input  wire logic signed [31:0]   scale_factor,
    input  wire logic signed [7:0]    exponent,
    output logic                      done,
    output logic signed [31:0]        result_re,
    output logic signed [31:0]        result_im,
    output logic [1:0]                status
);

    // The controller issues one command word per cycle; the datapath answers
    // with the zero-denominator flag that decides the division branch.
    cau_pkg::cmd_t  cmd;
    cau_pkg::stat_t stat;

    cau_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .opcode   (opcode),
        .exponent (exponent),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    // The datapath captures the request on the load command and holds the
    // result registers steady while done is shown.
    cau_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .opcode       (opcode),
        .operand_a_re (operand_a_re),
        .operand_a_im (operand_a_im),
        .operand_b_re (operand_b_re),
        .operand_b_im (operand_b_im),
        .scale_factor (scale_factor),
        .stat         (stat),
        .result_re    (result_re),
        .result_im    (result_im),
        .status       (status)
    );

endmodule

`default_nettype wire

// ----- design/cau_ctrl.sv -----
// Controller state machine that sequences the datapath for every operation.
`default_nettype none

module cau_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [3:0]           opcode,
    input  wire logic signed [7:0]    exponent,
    input  wire cau_pkg::stat_t       stat,
    output cau_pkg::cmd_t             cmd,
    output logic                      busy,
    output logic                      done
);

    typedef enum logic [10:0] {
        ST_IDLE    = 11'b000_0000_0001,
        ST_SIMPLE  = 11'b000_0000_0010,
        ST_MUL     = 11'b000_0000_0100,
        ST_ADD     = 11'b000_0000_1000,
        ST_POST    = 11'b000_0001_0000,
        ST_SQRT    = 11'b000_0010_0000,
        ST_DIV     = 11'b000_0100_0000,
        ST_FIN     = 11'b000_1000_0000,
        ST_POWINIT = 11'b001_0000_0000,
        ST_POWLOOP = 11'b010_0000_0000,
        ST_DONE    = 11'b100_0000_0000
    } state_t;

    // What the step after a multiply and add pass does with the sums.
    typedef enum logic [2:0] {
        PASS_PLAIN = 3'd0,
        PASS_NORM  = 3'd1,
        PASS_DEN   = 3'd2,
        PASS_NUM   = 3'd3,
        PASS_POW   = 3'd4
    } pass_t;

    state_t                             state_reg, state_next;
    pass_t                              pass_reg, pass_next;
    cau_pkg::mul_sel_t                  mul_sel_reg, mul_sel_next;
    cau_pkg::comb_t                     comb_reg, comb_next;
    logic                               is_pow_reg, is_pow_next;
    logic                               part_im_reg, part_im_next;
    logic [cau_pkg::STEP_W-1:0]         step_reg, step_next;
    logic [cau_pkg::POW_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [7:0]                         ex_mag;

    assign ex_mag = exponent[7] ? (8'd0 - exponent) : exponent;

    always_comb
    begin
        state_next   = state_reg;
        pass_next    = pass_reg;
        mul_sel_next = mul_sel_reg;
        comb_next    = comb_reg;
        is_pow_next  = is_pow_reg;
        part_im_next = part_im_reg;
        step_next    = step_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.mul_sel  = mul_sel_reg;
        cmd.comb     = comb_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load     = 1'b1;
                    is_pow_next  = 1'b0;
                    pass_next    = PASS_PLAIN;
                    comb_next    = cau_pkg::CM_SUM;
                    mul_sel_next = cau_pkg::MS_XY;
                    state_next   = ST_MUL;
                    case (cau_pkg::opcode_t'(opcode))
                        cau_pkg::OP_MUL:
                        begin
                            comb_next = cau_pkg::CM_MUL;
                        end
                        cau_pkg::OP_CONJMUL:
                        begin
                            comb_next = cau_pkg::CM_CONJ;
                        end
                        cau_pkg::OP_SCALE:
                        begin
                            mul_sel_next = cau_pkg::MS_SCALE;
                        end
                        cau_pkg::OP_NORMSQ:
                        begin
                            mul_sel_next = cau_pkg::MS_XX;
                        end
                        cau_pkg::OP_NORM:
                        begin
                            mul_sel_next = cau_pkg::MS_XX;
                            pass_next    = PASS_NORM;
                        end
                        cau_pkg::OP_DIV:
                        begin
                            mul_sel_next = cau_pkg::MS_YY;
                            pass_next    = PASS_DEN;
                        end
                        cau_pkg::OP_POW:
                        begin
                            is_pow_next = 1'b1;
                            if (32'(ex_mag) > 32'(cau_pkg::MAX_EXPONENT))
                            begin
                                cnt_next = cau_pkg::POW_CNT_W'(cau_pkg::MAX_EXPONENT);
                            end
                            else
                            begin
                                cnt_next = cau_pkg::POW_CNT_W'(ex_mag);
                            end
                            if (exponent[7])
                            begin
                                mul_sel_next = cau_pkg::MS_YY;
                                pass_next    = PASS_DEN;
                            end
                            else
                            begin
                                state_next = ST_POWINIT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_SIMPLE;
                        end
                    endcase
                end
            end
            ST_SIMPLE:
            begin
                cmd.simple_wr = 1'b1;
                state_next    = ST_DONE;
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add_en = 1'b1;
                state_next = ST_POST;
            end
            ST_POST:
            begin
                case (pass_reg)
                    PASS_NORM:
                    begin
                        cmd.sq_load = 1'b1;
                        step_next   = '0;
                        state_next  = ST_SQRT;
                    end
                    PASS_DEN:
                    begin
                        cmd.d_load = 1'b1;
                        if (stat.d_zero)
                        begin
                            cmd.dz_wr  = 1'b1;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            mul_sel_next = cau_pkg::MS_XY;
                            comb_next    = cau_pkg::CM_DIV;
                            pass_next    = PASS_NUM;
                            state_next   = ST_MUL;
                        end
                    end
                    PASS_NUM:
                    begin
                        cmd.div_load = 1'b1;
                        part_im_next = 1'b0;
                        step_next    = '0;
                        state_next   = ST_DIV;
                    end
                    PASS_POW:
                    begin
                        cmd.fix_wr = 1'b1;
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = ST_POWLOOP;
                    end
                    default:
                    begin
                        cmd.fix_wr = 1'b1;
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SQRT:
            begin
                cmd.sq_step = 1'b1;
                step_next   = step_reg + 1'b1;
                if (step_reg == cau_pkg::STEP_LAST)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == cau_pkg::STEP_LAST)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (pass_reg == PASS_NORM)
                begin
                    cmd.sq_wr  = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.div_wr  = 1'b1;
                    cmd.wr_im   = part_im_reg;
                    cmd.to_base = is_pow_reg;
                    if (!part_im_reg)
                    begin
                        cmd.div_load = 1'b1;
                        cmd.load_im  = 1'b1;
                        part_im_next = 1'b1;
                        step_next    = '0;
                        state_next   = ST_DIV;
                    end
                    else if (is_pow_reg)
                    begin
                        state_next = ST_POWINIT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_POWINIT:
            begin
                cmd.one_wr = 1'b1;
                state_next = ST_POWLOOP;
            end
            ST_POWLOOP:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mul_sel_next = cau_pkg::MS_POW;
                    comb_next    = cau_pkg::CM_MUL;
                    pass_next    = PASS_POW;
                    state_next   = ST_MUL;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pass_reg    <= PASS_PLAIN;
            mul_sel_reg <= cau_pkg::MS_XY;
            comb_reg    <= cau_pkg::CM_SUM;
            is_pow_reg  <= 1'b0;
            part_im_reg <= 1'b0;
            step_reg    <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pass_reg    <= pass_next;
            mul_sel_reg <= mul_sel_next;
            comb_reg    <= comb_next;
            is_pow_reg  <= is_pow_next;
            part_im_reg <= part_im_next;
            step_reg    <= step_next;
            cnt_reg     <= cnt_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule

`default_nettype wire

// ----- design/cau_dpath.sv -----
// Datapath: operand registers, four multipliers, adders, divider and square root.
`default_nettype none

module cau_dpath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cau_pkg::cmd_t        cmd,
    input  wire logic [3:0]           opcode,
    input  wire logic signed [31:0]   operand_a_re,
    input  wire logic signed [31:0]   operand_a_im,
    input  wire logic signed [31:0]   operand_b_re,
    input  wire logic signed [31:0]   operand_b_im,
    input  wire logic signed [31:0]   scale_factor,
    output cau_pkg::stat_t            stat,
    output logic signed [31:0]        result_re,
    output logic signed [31:0]        result_im,
    output logic [1:0]                status
);

    logic [3:0]          opcode_reg;
    logic signed [31:0]  x_re_reg, x_im_reg, y_re_reg, y_im_reg, fac_reg;
    logic signed [31:0]  base_re_reg, base_im_reg, res_re_reg, res_im_reg;
    logic                ov_reg, dz_reg;
    logic signed [63:0]  p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [64:0]  sum_re_reg, sum_im_reg;
    logic [63:0]         d_reg;
    logic [63:0]         rem_reg;
    logic [15:0]         nlow_reg;
    logic [31:0]         quo_reg;
    logic                dneg_reg, dovf_reg;
    logic [63:0]         sq_x_reg;
    logic [34:0]         sq_rem_reg;
    logic [31:0]         sq_root_reg;

    logic signed [31:0]  m0a, m0b, m1a, m1b, m2a, m2b, m3a, m3b;
    logic signed [64:0]  e0, e1, e2, e3, add_re, add_im;
    logic signed [32:0]  s_re, s_im;
    logic [32:0]         sr_re, sr_im, fx_re, fx_im, dres, sqres;
    logic signed [64:0]  num;
    logic [64:0]         num_mag;
    logic [64:0]         rem_sh;
    logic [34:0]         sq_sh, sq_trial;

    // Add, subtract, negate and conjugate work on the operands in one step.
    always_comb
    begin
        s_re = '0;
        s_im = '0;
        case (cau_pkg::opcode_t'(opcode_reg))
            cau_pkg::OP_ADD:
            begin
                s_re = 33'(x_re_reg) + 33'(y_re_reg);
                s_im = 33'(x_im_reg) + 33'(y_im_reg);
            end
            cau_pkg::OP_SUB:
            begin
                s_re = 33'(x_re_reg) - 33'(y_re_reg);
                s_im = 33'(x_im_reg) - 33'(y_im_reg);
            end
            cau_pkg::OP_NEG:
            begin
                s_re = 33'sd0 - 33'(x_re_reg);
                s_im = 33'sd0 - 33'(x_im_reg);
            end
            cau_pkg::OP_CONJ:
            begin
                s_re = 33'(x_re_reg);
                s_im = 33'sd0 - 33'(x_im_reg);
            end
            default:
            begin
                s_re = '0;
                s_im = '0;
            end
        endcase
    end

    assign sr_re = cau_pkg::sat33(s_re);
    assign sr_im = cau_pkg::sat33(s_im);

    always_comb
    begin
        m0a = x_re_reg;
        m0b = y_re_reg;
        m1a = x_im_reg;
        m1b = y_im_reg;
        m2a = x_re_reg;
        m2b = y_im_reg;
        m3a = x_im_reg;
        m3b = y_re_reg;
        case (cmd.mul_sel)
            cau_pkg::MS_YY:
            begin
                m0a = y_re_reg; m0b = y_re_reg;
                m1a = y_im_reg; m1b = y_im_reg;
                m2a = '0;       m2b = '0;
                m3a = '0;       m3b = '0;
            end
            cau_pkg::MS_XX:
            begin
                m0a = x_re_reg; m0b = x_re_reg;
                m1a = x_im_reg; m1b = x_im_reg;
                m2a = '0;       m2b = '0;
                m3a = '0;       m3b = '0;
            end
            cau_pkg::MS_SCALE:
            begin
                m0a = x_re_reg; m0b = fac_reg;
                m1a = '0;       m1b = '0;
                m2a = x_im_reg; m2b = fac_reg;
                m3a = '0;       m3b = '0;
            end
            cau_pkg::MS_POW:
            begin
                m0a = res_re_reg; m0b = base_re_reg;
                m1a = res_im_reg; m1b = base_im_reg;
                m2a = res_re_reg; m2b = base_im_reg;
                m3a = res_im_reg; m3b = base_re_reg;
            end
            default:
            begin
                m0a = x_re_reg;
            end
        endcase
    end

    assign e0 = 65'(p0_reg);
    assign e1 = 65'(p1_reg);
    assign e2 = 65'(p2_reg);
    assign e3 = 65'(p3_reg);

    always_comb
    begin
        case (cmd.comb)
            cau_pkg::CM_MUL:
            begin
                add_re = e0 - e1;
                add_im = e2 + e3;
            end
            cau_pkg::CM_CONJ:
            begin
                add_re = e0 + e1;
                add_im = e2 - e3;
            end
            cau_pkg::CM_DIV:
            begin
                add_re = e0 + e1;
                add_im = e3 - e2;
            end
            default:
            begin
                add_re = e0 + e1;
                add_im = e2 + e3;
            end
        endcase
    end

    assign fx_re = cau_pkg::fix_q(sum_re_reg);
    assign fx_im = cau_pkg::fix_q(sum_im_reg);

    // Divider: restoring, one quotient bit per cycle.
    assign num     = cmd.load_im ? sum_im_reg : sum_re_reg;
    assign num_mag = num[64] ? 65'(65'sd0 - num) : 65'(num);
    assign rem_sh  = {rem_reg, nlow_reg[15]};
    assign dres    = cau_pkg::sat_sm(dneg_reg, dovf_reg ? '1 : 65'(quo_reg));

    // Square root: two radicand bits per cycle.
    assign sq_sh    = {sq_rem_reg[32:0], sq_x_reg[63:62]};
    assign sq_trial = {1'b0, sq_root_reg, 2'b01};
    assign sqres    = cau_pkg::sat_sm(1'b0, 65'(sq_root_reg));

    assign stat.d_zero = (sum_re_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            opcode_reg  <= opcode;
            fac_reg     <= scale_factor;
            base_re_reg <= operand_a_re;
            base_im_reg <= operand_a_im;
            res_re_reg  <= '0;
            res_im_reg  <= '0;
            if (cau_pkg::opcode_t'(opcode) == cau_pkg::OP_POW)
            begin
                x_re_reg <= cau_pkg::Q_ONE;
                x_im_reg <= '0;
                y_re_reg <= operand_a_re;
                y_im_reg <= operand_a_im;
            end
            else
            begin
                x_re_reg <= operand_a_re;
                x_im_reg <= operand_a_im;
                y_re_reg <= operand_b_re;
                y_im_reg <= operand_b_im;
            end
        end
        if (cmd.simple_wr)
        begin
            res_re_reg <= sr_re[31:0];
            res_im_reg <= sr_im[31:0];
        end
        if (cmd.fix_wr)
        begin
            res_re_reg <= fx_re[31:0];
            res_im_reg <= fx_im[31:0];
        end
        if (cmd.dz_wr)
        begin
            res_re_reg <= '0;
            res_im_reg <= '0;
        end
        if (cmd.div_wr)
        begin
            if (cmd.to_base)
            begin
                if (cmd.wr_im)
                begin
                    base_im_reg <= dres[31:0];
                end
                else
                begin
                    base_re_reg <= dres[31:0];
                end
            end
            else if (cmd.wr_im)
            begin
                res_im_reg <= dres[31:0];
            end
            else
            begin
                res_re_reg <= dres[31:0];
            end
        end
        if (cmd.sq_wr)
        begin
            res_re_reg <= sqres[31:0];
            res_im_reg <= '0;
        end
        if (cmd.one_wr)
        begin
            res_re_reg <= cau_pkg::Q_ONE;
            res_im_reg <= '0;
        end
        if (cmd.mul_en)
        begin
            p0_reg <= m0a * m0b;
            p1_reg <= m1a * m1b;
            p2_reg <= m2a * m2b;
            p3_reg <= m3a * m3b;
        end
        if (cmd.add_en)
        begin
            sum_re_reg <= add_re;
            sum_im_reg <= add_im;
        end
        if (cmd.d_load)
        begin
            d_reg <= sum_re_reg[63:0];
        end
        if (cmd.div_load)
        begin
            rem_reg  <= {16'h0, num_mag[63:16]};
            nlow_reg <= num_mag[15:0];
            dneg_reg <= num[64];
            dovf_reg <= ({16'h0, num_mag[63:16]} >= d_reg);
            quo_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            nlow_reg <= {nlow_reg[14:0], 1'b0};
            if (rem_sh >= {1'b0, d_reg})
            begin
                rem_reg <= 64'(rem_sh - {1'b0, d_reg});
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[63:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
        if (cmd.sq_load)
        begin
            sq_x_reg    <= sum_re_reg[63:0];
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end
        else if (cmd.sq_step)
        begin
            sq_x_reg <= {sq_x_reg[61:0], 2'b00};
            if (sq_sh >= sq_trial)
            begin
                sq_rem_reg  <= sq_sh - sq_trial;
                sq_root_reg <= {sq_root_reg[30:0], 1'b1};
            end
            else
            begin
                sq_rem_reg  <= sq_sh;
                sq_root_reg <= {sq_root_reg[30:0], 1'b0};
            end
        end
    end

    // Overflow is sticky across the steps of one request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            dz_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            ov_reg <= 1'b0;
            dz_reg <= 1'b0;
        end
        else
        begin
            if (cmd.simple_wr)
            begin
                ov_reg <= ov_reg | sr_re[32] | sr_im[32];
            end
            if (cmd.fix_wr)
            begin
                ov_reg <= ov_reg | fx_re[32] | fx_im[32];
            end
            if (cmd.div_wr)
            begin
                ov_reg <= ov_reg | dres[32];
            end
            if (cmd.sq_wr)
            begin
                ov_reg <= ov_reg | sqres[32];
            end
            if (cmd.dz_wr)
            begin
                dz_reg <= 1'b1;
            end
        end
    end

    assign result_re = res_re_reg;
    assign result_im = res_im_reg;
    assign status    = dz_reg ? cau_pkg::STATUS_DIVZERO :
                       (ov_reg ? cau_pkg::STATUS_OVF : cau_pkg::STATUS_OK);

endmodule

`default_nettype wire

// ----- design/cau_checker.sv -----
// Port-level checks of the complex arithmetic unit and their binding.
`default_nettype none

module cau_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               done,
    input wire logic signed [31:0] result_re,
    input wire logic signed [31:0] result_im,
    input wire logic [1:0]         status
);

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done shown while idle");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == cau_pkg::STATUS_OK || status == cau_pkg::STATUS_OVF ||
                  status == cau_pkg::STATUS_DIVZERO))
        else $error("undefined status code");

    a_divzero_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == cau_pkg::STATUS_DIVZERO) |-> (result_re == 0 && result_im == 0))
        else $error("division by zero with nonzero result");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .result_re (result_re),
    .result_im (result_im),
    .status    (status)
);

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench of the complex arithmetic unit with its own Q16.16 predictor.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Opcodes 11 to 15 have no operation behind them and must give a zero result.
    localparam logic [3:0] OP_UNUSED_LO = 4'd11;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // Wide signed arithmetic: all sums of two Q32.32 products and the
    // scaled dividends fit here without any loss.
    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [1:0]         st;
    } cplx_result_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [3:0]          opcode;
    logic signed [31:0]  operand_a_re;
    logic signed [31:0]  operand_a_im;
    logic signed [31:0]  operand_b_re;
    logic signed [31:0]  operand_b_im;
    logic signed [31:0]  scale_factor;
    logic signed [7:0]   exponent;
    logic                done;
    logic signed [31:0]  result_re;
    logic signed [31:0]  result_im;
    logic [1:0]          status;

    // Results that the block still owes us, oldest first.
    cplx_result_t pending_results[$];
    int           error_count;
    // Number of requests left in the current burst of the sender.
    int           burst_left;

    complex_arithmetic_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .operand_a_re (operand_a_re),
        .operand_a_im (operand_a_im),
        .operand_b_re (operand_b_re),
        .operand_b_im (operand_b_im),
        .scale_factor (scale_factor),
        .exponent     (exponent),
        .done         (done),
        .result_re    (result_re),
        .result_im    (result_im),
        .status       (status)
    );

    // 20 ns clock.
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // ------------------------------------------------------------------
    // Predictor of the datapath.
    // ------------------------------------------------------------------

    // Clamp to the 32-bit signed range and raise the overflow flag if needed.
    function automatic logic signed [31:0] clamp_q(input wide_t v, inout bit ovf);
        if (v > wide_t'(Q_MAX)) begin
            ovf = 1'b1;
            return Q_MAX;
        end
        if (v < wide_t'(Q_MIN)) begin
            ovf = 1'b1;
            return Q_MIN;
        end
        return v[31:0];
    endfunction

    // Q32.32 to Q16.16: the arithmetic shift floors toward minus infinity.
    function automatic logic signed [31:0] floor_q(input wide_t v, inout bit ovf);
        return clamp_q(v >>> 16, ovf);
    endfunction

    // Quotient in Q16.16 of two Q32.32 values, truncated toward zero.
    function automatic logic signed [31:0] quot_q(input wide_t n, input wide_t d,
                                                  inout bit ovf);
        wide_t mag;
        wide_t q;
        mag = (n < 0) ? -n : n;
        q   = (mag <<< 16) / d;
        return clamp_q((n < 0) ? -q : q, ovf);
    endfunction

    // Floor of the square root, built one bit at a time from the top.
    function automatic wide_t floor_sqrt(input wide_t x);
        wide_t r;
        wide_t t;
        r = 0;
        for (int i = 32; i >= 0; i--) begin
            t = r | (wide_t'(1) <<< i);
            if (t * t <= x) begin
                r = t;
            end
        end
        return r;
    endfunction

    // Complex product of two Q16.16 numbers.
    function automatic void cplx_mul(input wide_t ar, input wide_t ai, input wide_t br,
                                     input wide_t bi, output logic signed [31:0] re,
                                     output logic signed [31:0] im, inout bit ovf);
        re = floor_q(ar * br - ai * bi, ovf);
        im = floor_q(ar * bi + ai * br, ovf);
    endfunction

    // Complex quotient; returns 0 when the divisor is exactly zero.
    function automatic bit cplx_div(input wide_t ar, input wide_t ai, input wide_t br,
                                    input wide_t bi, output logic signed [31:0] re,
                                    output logic signed [31:0] im, inout bit ovf);
        wide_t d;
        d  = br * br + bi * bi;
        re = '0;
        im = '0;
        if (d == 0) begin
            return 1'b0;
        end
        re = quot_q(ar * br + ai * bi, d, ovf);
        im = quot_q(ai * br - ar * bi, d, ovf);
        return 1'b1;
    endfunction

    function automatic cplx_result_t compute_result(input logic [3:0] op,
                                                    input logic signed [31:0] a_re,
                                                    input logic signed [31:0] a_im,
                                                    input logic signed [31:0] b_re,
                                                    input logic signed [31:0] b_im,
                                                    input logic signed [31:0] fac,
                                                    input logic signed [7:0] ex);
        cplx_result_t       r;
        bit                 ovf;
        bit                 dz;
        wide_t              ar;
        wide_t              ai;
        wide_t              br;
        wide_t              bi;
        int                 steps;
        logic signed [31:0] base_re;
        logic signed [31:0] base_im;
        logic signed [31:0] nre;
        logic signed [31:0] nim;
        ovf  = 1'b0;
        dz   = 1'b0;
        r.re = '0;
        r.im = '0;
        ar   = a_re;
        ai   = a_im;
        br   = b_re;
        bi   = b_im;
        case (op)
            cau_pkg::OP_ADD:
            begin
                r.re = clamp_q(ar + br, ovf);
                r.im = clamp_q(ai + bi, ovf);
            end
            cau_pkg::OP_SUB:
            begin
                r.re = clamp_q(ar - br, ovf);
                r.im = clamp_q(ai - bi, ovf);
            end
            cau_pkg::OP_MUL:
            begin
                cplx_mul(ar, ai, br, bi, r.re, r.im, ovf);
            end
            cau_pkg::OP_CONJMUL:
            begin
                r.re = floor_q(ar * br + ai * bi, ovf);
                r.im = floor_q(ar * bi - ai * br, ovf);
            end
            cau_pkg::OP_DIV:
            begin
                dz = !cplx_div(ar, ai, br, bi, r.re, r.im, ovf);
            end
            cau_pkg::OP_NEG:
            begin
                r.re = clamp_q(-ar, ovf);
                r.im = clamp_q(-ai, ovf);
            end
            cau_pkg::OP_CONJ:
            begin
                r.re = a_re;
                r.im = clamp_q(-ai, ovf);
            end
            cau_pkg::OP_SCALE:
            begin
                r.re = floor_q(ar * wide_t'(fac), ovf);
                r.im = floor_q(ai * wide_t'(fac), ovf);
            end
            cau_pkg::OP_NORMSQ:
            begin
                r.re = floor_q(ar * ar + ai * ai, ovf);
            end
            cau_pkg::OP_NORM:
            begin
                r.re = clamp_q(floor_sqrt(ar * ar + ai * ai), ovf);
            end
            cau_pkg::OP_POW:
            begin
                steps = (ex < 0) ? -int'(ex) : int'(ex);
                if (steps > cau_pkg::MAX_EXPONENT) begin
                    steps = cau_pkg::MAX_EXPONENT;
                end
                r.re    = cau_pkg::Q_ONE;
                base_re = a_re;
                base_im = a_im;
                if (ex < 0) begin
                    dz = !cplx_div(wide_t'(cau_pkg::Q_ONE), 0, ar, ai, base_re, base_im,
                                   ovf);
                end
                if (!dz) begin
                    for (int i = 0; i < steps; i++) begin
                        cplx_mul(r.re, r.im, base_re, base_im, nre, nim, ovf);
                        r.re = nre;
                        r.im = nim;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (dz) begin
            r.re = '0;
            r.im = '0;
            r.st = cau_pkg::STATUS_DIVZERO;
        end
        else begin
            r.st = ovf ? cau_pkg::STATUS_OVF : cau_pkg::STATUS_OK;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request driver. Inputs change on the falling edge; a request is taken
    // at the rising edge where start is high and busy is low. The sender
    // works in bursts, lowering start for a random gap between them.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [3:0] op, input logic signed [31:0] a_re,
                                input logic signed [31:0] a_im,
                                input logic signed [31:0] b_re,
                                input logic signed [31:0] b_im,
                                input logic signed [31:0] fac,
                                input logic signed [7:0] ex);
        int gap;
        @(negedge clk);
        opcode       = op;
        operand_a_re = a_re;
        operand_a_im = a_im;
        operand_b_re = b_re;
        operand_b_im = b_im;
        scale_factor = fac;
        exponent     = ex;
        start        = 1'b1;
        // busy read here still holds its value from before this edge.
        forever begin
            @(posedge clk);
            if (!busy) begin
                break;
            end
        end
        pending_results.push_back(compute_result(op, a_re, a_im, b_re, b_im, fac, ex));
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            // End of a burst: drop start and scramble opcode, operand_a_re and exponent.
            @(negedge clk);
            start        = 1'b0;
            opcode       = 4'($urandom);
            operand_a_re = $urandom;
            exponent     = 8'($urandom);
            gap          = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) @(negedge clk);
            // Some bursts are long, giving stretches with no idling at all.
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        error_count++;
    endtask

    // Result checker: every done strobe is compared with the oldest request.
    always @(posedge clk)
    begin
        cplx_result_t want;
        if (rst_n && done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end
            else begin
                want = pending_results.pop_front();
                if (result_re !== want.re) begin
                    report_mismatch($sformatf("result_re %h, expected %h", result_re, want.re));
                end
                if (result_im !== want.im) begin
                    report_mismatch($sformatf("result_im %h, expected %h", result_im, want.im));
                end
                if (status !== want.st) begin
                    report_mismatch($sformatf("status %0d, expected %0d", status, want.st));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Random operand shapes: full range, small magnitudes, zero and the extremes.
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(0, 9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3, 4:    return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
            5:       return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
            default: return $urandom;
        endcase
    endfunction

    // Pow base mostly kept to components within plus or minus one so long products stay interesting.
    function automatic logic signed [31:0] rand_base();
        if ($urandom_range(0, 4) == 0) begin
            return rand_q();
        end
        return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
    endfunction

    function automatic logic signed [7:0] rand_exponent();
        case ($urandom_range(0, 9))
            0:       return 8'($urandom);
            1:       return 8'($signed($urandom_range(0, 128)) - 64);
            default: return 8'($signed($urandom_range(0, 16)) - 8);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------
    task automatic test_add_sub_extremes();
        send_request(cau_pkg::OP_ADD, Q_MAX, Q_MIN, Q_MAX, Q_MIN, '0, '0);
        send_request(cau_pkg::OP_ADD, Q_MAX, Q_MIN, 32'sd1, -32'sd1, '0, '0);
        send_request(cau_pkg::OP_SUB, Q_MIN, Q_MAX, Q_MAX, Q_MIN, '0, '0);
        send_request(cau_pkg::OP_SUB, 32'sd5, -32'sd5, 32'sd7, 32'sd3, '0, '0);
    endtask

    task automatic test_products();
        send_request(cau_pkg::OP_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MAX, '0, '0);
        send_request(cau_pkg::OP_MUL, -32'sd1, 32'sd1, 32'sd1, 32'sd1, '0, '0);
        send_request(cau_pkg::OP_CONJMUL, Q_MAX, Q_MIN, Q_MIN, Q_MAX, '0, '0);
        send_request(cau_pkg::OP_SCALE, Q_MIN, Q_MAX, '0, '0, Q_MIN, '0);
        send_request(cau_pkg::OP_SCALE, -32'sd3, 32'sd3, '0, '0, 32'sh0000_8000, '0);
    endtask

    task automatic test_division();
        // Division by an exact zero, and a tiny divisor that overflows.
        send_request(cau_pkg::OP_DIV, Q_MAX, Q_MAX, '0, '0, '0, '0);
        send_request(cau_pkg::OP_DIV, Q_MIN, Q_MAX, 32'sd1, '0, '0, '0);
        send_request(cau_pkg::OP_DIV, cau_pkg::Q_ONE, '0, Q_MIN, Q_MIN, '0, '0);
        send_request(cau_pkg::OP_DIV, -32'sd7, 32'sd3, 32'sd2, -32'sd5, '0, '0);
    endtask

    task automatic test_sign_ops();
        // Negating the most negative value must saturate.
        send_request(cau_pkg::OP_NEG, Q_MIN, Q_MAX, '0, '0, '0, '0);
        send_request(cau_pkg::OP_CONJ, Q_MIN, Q_MIN, '0, '0, '0, '0);
        send_request(cau_pkg::OP_CONJ, Q_MAX, Q_MAX, '0, '0, '0, '0);
    endtask

    task automatic test_norms();
        send_request(cau_pkg::OP_NORMSQ, Q_MIN, Q_MIN, '0, '0, '0, '0);
        send_request(cau_pkg::OP_NORMSQ, 32'sd1, -32'sd1, '0, '0, '0, '0);
        send_request(cau_pkg::OP_NORM, Q_MIN, Q_MIN, '0, '0, '0, '0);
        send_request(cau_pkg::OP_NORM, 32'sd3, 32'sd4, '0, '0, '0, '0);
    endtask

    task automatic test_power();
        // Zero exponent on a zero base, reciprocal of zero, and clamped exponents.
        send_request(cau_pkg::OP_POW, '0, '0, '0, '0, '0, 8'sd0);
        send_request(cau_pkg::OP_POW, '0, '0, '0, '0, '0, -8'sd1);
        send_request(cau_pkg::OP_POW, 32'sh0001_0100, -32'sh0000_0200, '0, '0, '0, 8'sd127);
        send_request(cau_pkg::OP_POW, 32'sh0000_FF00, 32'sh0000_0100, '0, '0, '0, -8'sd128);
        send_request(cau_pkg::OP_POW, Q_MAX, Q_MIN, '0, '0, '0, 8'sd2);
        send_request(cau_pkg::OP_POW, 32'sd1, '0, '0, '0, '0, -8'sd3);
    endtask

    task automatic test_unused_opcodes();
        send_request(OP_UNUSED_LO, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 8'sd5);
        send_request(OP_UNUSED_HI, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, -8'sd5);
    endtask

    task automatic test_random_mix(input int count);
        logic [3:0] op;
        for (int n = 0; n < count; n++) begin
            op = ($urandom_range(0, 19) == 0)
                 ? 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI))
                 : 4'($urandom_range(cau_pkg::OP_ADD, cau_pkg::OP_POW));
            if (op == cau_pkg::OP_POW) begin
                send_request(op, rand_base(), rand_base(), $urandom, $urandom, $urandom,
                             rand_exponent());
            end
            else begin
                send_request(op, rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
                             8'($urandom));
            end
        end
    endtask

    // Hard stop in case the block hangs.
    initial
    begin
        #40ms;
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        int wait_cycles;
        error_count  = 0;
        burst_left   = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = '0;
        operand_a_re = '0;
        operand_a_im = '0;
        operand_b_re = '0;
        operand_b_im = '0;
        scale_factor = '0;
        exponent     = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_add_sub_extremes();
        test_products();
        test_division();
        test_sign_ops();
        test_norms();
        test_power();
        test_unused_opcodes();
        test_random_mix(1400);

        @(negedge clk);
        start = 1'b0;
        // Drain the outstanding result, then allow one longest operation more.
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 2000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (400) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("tb_top passed");
        end
        else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
